// ===== src/pmid_pkg.sv =====
package pmid_pkg;

  // coordinate width actually used from each input field (16 .. 32 here)
  localparam int CoordW  = 32;
  localparam int FieldW  = 32;
  localparam int BoxW    = 31;
  localparam int DistW   = 32;
  localparam int SqW     = 2 * DistW;
  localparam int SumW    = SqW + 2;
  localparam int DiffW   = CoordW + 1;
  // candidates d, d-a, d+a with one spare bit for the sign
  localparam int CandW   = ((DiffW > BoxW) ? DiffW : BoxW + 1) + 1;
  localparam int NumAxes = 3;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgBoxX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBoxZ = 2'd2;

  typedef logic [NumAxes-1:0][BoxW-1:0] box_vec_t;

  typedef struct packed {
    logic signed [FieldW-1:0] point_x;
    logic signed [FieldW-1:0] point_y;
    logic signed [FieldW-1:0] point_z;
    logic signed [FieldW-1:0] atom_x;
    logic signed [FieldW-1:0] atom_y;
    logic signed [FieldW-1:0] atom_z;
    logic                     last_pair;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance_out;
    logic             saturated;
    logic             last_out;
  } out_item_t;

  // sum of squares handed from the front end to the root pipeline
  typedef struct packed {
    logic [SqW-1:0] sum;
    logic           sat;
    logic           last;
  } sq_item_t;

endpackage

// ===== src/pmid_front.sv =====
module pmid_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmid_pkg::box_vec_t box_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pmid_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pmid_pkg::sq_item_t out_item_o
);
  import pmid_pkg::*;

  localparam int NumStg = 4;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_in;
  logic [NumStg:0]   rdy;

  logic [NumAxes-1:0][CoordW-1:0] pnt, atm;

  // stage 1: candidates per axis
  logic [NumAxes-1:0][CandW-1:0] c0_d, c1_d, c2_d, c0_q, c1_q, c2_q;
  logic                          last1_q;
  // stage 2: minimum magnitude per axis
  logic [NumAxes-1:0][DistW-1:0] mag_d, mag_q;
  logic                          over2_d, over2_q, last2_q;
  // stage 3: squares
  logic [NumAxes-1:0][SqW-1:0]   sq_d, sq_q;
  logic                          over3_q, last3_q;
  // stage 4: sum
  logic [SumW-1:0]               sum_d;
  sq_item_t                      res_d, res_q;

  assign pnt[0] = in_item_i.point_x[CoordW-1:0];
  assign pnt[1] = in_item_i.point_y[CoordW-1:0];
  assign pnt[2] = in_item_i.point_z[CoordW-1:0];
  assign atm[0] = in_item_i.atom_x[CoordW-1:0];
  assign atm[1] = in_item_i.atom_y[CoordW-1:0];
  assign atm[2] = in_item_i.atom_z[CoordW-1:0];

  always_comb begin
    logic [DiffW-1:0] diff;
    logic [CandW-1:0] box_ext;
    for (int k = 0; k < NumAxes; k++) begin
      diff    = {pnt[k][CoordW-1], pnt[k]} - {atm[k][CoordW-1], atm[k]};
      box_ext = {{(CandW-BoxW){1'b0}}, box_i[k]};
      c0_d[k] = {{(CandW-DiffW){diff[DiffW-1]}}, diff};
      c1_d[k] = c0_d[k] - box_ext;
      c2_d[k] = c0_d[k] + box_ext;
    end
  end

  always_comb begin
    logic [CandW-1:0] a0, a1, a2, m;
    over2_d = 1'b0;
    for (int k = 0; k < NumAxes; k++) begin
      a0 = c0_q[k][CandW-1] ? (~c0_q[k] + CandW'(1)) : c0_q[k];
      a1 = c1_q[k][CandW-1] ? (~c1_q[k] + CandW'(1)) : c1_q[k];
      a2 = c2_q[k][CandW-1] ? (~c2_q[k] + CandW'(1)) : c2_q[k];
      m  = (a0 < a1) ? a0 : a1;
      m  = (m < a2) ? m : a2;
      mag_d[k] = m[DistW-1:0];
      over2_d  = over2_d | (|m[CandW-1:DistW]);
    end
  end

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      sq_d[k] = SqW'(mag_q[k]) * SqW'(mag_q[k]);
    end
  end

  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  always_comb begin
    res_d.sum  = sum_d[SqW-1:0];
    res_d.sat  = over3_q | (|sum_d[SumW-1:SqW]);
    res_d.last = last3_q;
  end

  // elastic chain: a stage takes new data when empty or when its successor moves
  assign rdy[NumStg] = out_ready_i;
  for (genvar s = 0; s < NumStg; s++) begin : g_rdy
    assign rdy[s] = ~vld_q[s] | rdy[s+1];
  end

  assign vld_in = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NumStg; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      last1_q <= in_item_i.last_pair;
    end
    if (rdy[1]) begin
      mag_q   <= mag_d;
      over2_q <= over2_d;
      last2_q <= last1_q;
    end
    if (rdy[2]) begin
      sq_q    <= sq_d;
      over3_q <= over2_q;
      last3_q <= last2_q;
    end
    if (rdy[3]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign out_item_o  = res_q;

endmodule

// ===== src/pmid_sqrt.sv =====
module pmid_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pmid_pkg::sq_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pmid_pkg::out_item_t out_item_o
);
  import pmid_pkg::*;

  // one root bit per stage, restoring method
  localparam int RootW = DistW;
  localparam int RemW  = RootW + 1;
  localparam int TryW  = RootW + 3;

  logic [RootW-1:0] vld_q;
  logic [RootW:0]   rdy;

  logic [RootW-1:0][SqW-1:0]   n_q;
  logic [RootW-1:0][RemW-1:0]  rem_q;
  logic [RootW-1:0][RootW-1:0] root_q;
  logic [RootW-1:0]            sat_q, last_q;

  // out-of-range sums become all ones, whose floor root is the maximum output
  logic [SqW-1:0] n_in;
  assign n_in = in_item_i.sat ? {SqW{1'b1}} : in_item_i.sum;

  assign rdy[RootW] = out_ready_i;

  for (genvar s = 0; s < RootW; s++) begin : g_stg
    logic [SqW-1:0]   n_prev, n_d;
    logic [RemW-1:0]  rem_prev, rem_d;
    logic [RootW-1:0] root_prev, root_d;
    logic             vld_prev, sat_prev, last_prev;
    logic [TryW-1:0]  rem_sh, trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign n_prev    = n_in;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign vld_prev  = in_valid_i;
      assign sat_prev  = in_item_i.sat;
      assign last_prev = in_item_i.last;
    end else begin : g_next
      assign n_prev    = n_q[s-1];
      assign rem_prev  = rem_q[s-1];
      assign root_prev = root_q[s-1];
      assign vld_prev  = vld_q[s-1];
      assign sat_prev  = sat_q[s-1];
      assign last_prev = last_q[s-1];
    end

    assign rem_sh = {rem_prev, n_prev[SqW-1:SqW-2]};
    assign trial  = {1'b0, root_prev, 2'b01};
    assign ge     = rem_sh >= trial;
    always_comb begin
      logic [TryW-1:0] diff;
      diff   = rem_sh - trial;
      rem_d  = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_d = {root_prev[RootW-2:0], ge};
      n_d    = {n_prev[SqW-3:0], 2'b00};
    end

    assign rdy[s] = ~vld_q[s] | rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        n_q[s]    <= n_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        sat_q[s]  <= sat_prev;
        last_q[s] <= last_prev;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[RootW-1];
  always_comb begin
    out_item_o.distance_out = root_q[RootW-1];
    out_item_o.saturated    = sat_q[RootW-1];
    out_item_o.last_out     = last_q[RootW-1];
  end

endmodule

// ===== src/periodic_min_image_distance_top.sv =====
// Pipeline: 4 front-end stages, then 32 square-root stages, from an accepted
// request to its result.
// Throughput: one request per cycle unless the output stalls; the 32-stage root
// pipeline, one result bit per stage, sets depth. Bubbles collapse in a stall.
// Reset: pipeline valid bits and the three box lengths clear to zero.
module periodic_min_image_distance_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pmid_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pmid_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pmid_pkg::FieldW-1:0]   cfg_data_i
);
  import pmid_pkg::*;

  box_vec_t box_q;
  logic     front_ready;
  logic     mid_valid, mid_ready;
  sq_item_t mid_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgBoxX: box_q[0] <= cfg_data_i[BoxW-1:0];
        CfgBoxY: box_q[1] <= cfg_data_i[BoxW-1:0];
        CfgBoxZ: box_q[2] <= cfg_data_i[BoxW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  pmid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_i       (box_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .in_item_i   (in_item_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_item_o  (mid_item)
  );

  pmid_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_item_i   (mid_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (~out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = ~front_ready;

endmodule

// ===== bench/periodic_min_image_distance_top_test.sv =====
module periodic_min_image_distance_top_test;
  import pmid_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [31:0] One = 32'h0001_0000;
  localparam int WideW = 40;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [FieldW-1:0]   cfg_data = '0;

  periodic_min_image_distance_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // box lengths as the block should hold them
  logic [BoxW-1:0] box_len [NumAxes];

  in_item_t  pair_q [$];
  out_item_t dist_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_len = 0;
  int err_cnt = 0;
  int pairs_sent = 0;
  int dists_checked = 0;
  int sat_seen = 0;
  int box_writes = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // distance predictor

  function automatic logic [WideW-1:0] nearest_image(logic [FieldW-1:0] p,
                                                     logic [FieldW-1:0] q,
                                                     logic [BoxW-1:0] a);
    logic signed [WideW-1:0] ps, qs, d, av, c0, c1, c2, m;
    ps = {{(WideW-CoordW){p[CoordW-1]}}, p[CoordW-1:0]};
    qs = {{(WideW-CoordW){q[CoordW-1]}}, q[CoordW-1:0]};
    av = {{(WideW-BoxW){1'b0}}, a};
    d  = ps - qs;
    c0 = (d < 0) ? -d : d;
    c1 = (d - av < 0) ? av - d : d - av;
    c2 = (d + av < 0) ? -(d + av) : d + av;
    m  = (c1 < c0) ? c1 : c0;
    m  = (c2 < m) ? c2 : m;
    return m;
  endfunction

  function automatic logic [DistW-1:0] floor_root(logic [SqW-1:0] n);
    logic [DistW-1:0] r;
    logic [SqW-1:0]   t;
    r = '0;
    for (int b = DistW - 1; b >= 0; b--) begin
      t = SqW'(r | (DistW'(1) << b));
      if (t * t <= n) r = t[DistW-1:0];
    end
    return r;
  endfunction

  function automatic out_item_t predict_distance(in_item_t req);
    logic [WideW-1:0]   m [NumAxes];
    logic [2*WideW-1:0] sum;
    out_item_t          res;
    m[0] = nearest_image(req.point_x, req.atom_x, box_len[0]);
    m[1] = nearest_image(req.point_y, req.atom_y, box_len[1]);
    m[2] = nearest_image(req.point_z, req.atom_z, box_len[2]);
    sum = '0;
    for (int i = 0; i < NumAxes; i++) begin
      sum += {{WideW{1'b0}}, m[i]} * {{WideW{1'b0}}, m[i]};
    end
    res.saturated = (sum >> SqW) != 0;
    res.distance_out = res.saturated ? '1 : floor_root(sum[SqW-1:0]);
    res.last_out = req.last_pair;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // register shadow

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      for (int i = 0; i < NumAxes; i++) box_len[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      box_writes++;
      case (cfg_index)
        CfgBoxX: box_len[0] <= cfg_data[BoxW-1:0];
        CfgBoxY: box_len[1] <= cfg_data[BoxW-1:0];
        CfgBoxZ: box_len[2] <= cfg_data[BoxW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request driver

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        dist_q.push_back(predict_distance(in_item));
        pairs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (pair_q.size() != 0) begin
          in_item  <= pair_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor

  always @(posedge clk or negedge rst_n) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          $error("result with no pending request: distance_out %h", out_item.distance_out);
          err_cnt++;
        end else begin
          want = dist_q.pop_front();
          dists_checked++;
          if (want.saturated) sat_seen++;
          if (out_item.distance_out !== want.distance_out) begin
            $error("distance_out: expected %h, got %h", want.distance_out,
                   out_item.distance_out);
            err_cnt++;
          end
          if (out_item.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, out_item.saturated);
            err_cnt++;
          end
          if (out_item.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, out_item.last_out);
            err_cnt++;
          end
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  task automatic write_box(input logic [CfgIdxW-1:0] idx, input logic [FieldW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_boxes(input logic [FieldW-1:0] bx, input logic [FieldW-1:0] by,
                           input logic [FieldW-1:0] bz);
    write_box(CfgBoxX, bx);
    write_box(CfgBoxY, by);
    write_box(CfgBoxZ, bz);
    @(negedge clk);
  endtask

  task automatic add_pair(input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] pz, input logic [31:0] ax,
                          input logic [31:0] ay, input logic [31:0] az, input logic lst);
    in_item_t r;
    r.point_x = px;
    r.point_y = py;
    r.point_z = pz;
    r.atom_x  = ax;
    r.atom_y  = ay;
    r.atom_z  = az;
    r.last_pair = lst;
    pair_q.push_back(r);
  endtask

  // wait until every request has been sent and answered
  task automatic drain();
    do @(negedge clk); while (pair_q.size() != 0 || in_valid || dist_q.size() != 0);
  endtask

  // mostly separations up to one box length or a fixed span, where the wrap choice matters
  function automatic in_item_t random_pair();
    in_item_t    r;
    int unsigned mode;
    logic [31:0] p [NumAxes];
    logic [31:0] q [NumAxes];
    longint      span, off;
    mode = $urandom_range(0, 3);
    for (int ax = 0; ax < NumAxes; ax++) begin
      if (mode == 0) begin
        p[ax] = $urandom;
        q[ax] = $urandom;
      end else begin
        span = (box_len[ax] == 0) ? 64'h0010_0000 : longint'(box_len[ax]);
        if (mode == 3) span = 64'h0010_0000;
        q[ax] = (mode == 1) ? $urandom : 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
        off = longint'($urandom_range(0, 32'(2 * span))) - span;
        p[ax] = q[ax] + off[31:0];
      end
    end
    r.point_x = p[0];
    r.point_y = p[1];
    r.point_z = p[2];
    r.atom_x  = q[0];
    r.atom_y  = q[1];
    r.atom_z  = q[2];
    r.last_pair = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  task automatic run_phase(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) pair_q.push_back(random_pair());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // boxes still zero: plain distances and the edges of the output range
    add_pair(0, 0, 0, 0, 0, 0, 1'b0);
    add_pair(One, One, One, 0, 0, 0, 1'b1);
    add_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1'b0);
    add_pair(32'h7FFF_FFFF, 32'd92681, 0, 32'h8000_0000, 0, 0, 1'b0);
    add_pair(32'h7FFF_FFFF, 32'd92682, 0, 32'h8000_0000, 0, 0, 1'b1);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFF, 0, 0, 1, 0, 0, 1'b0);
    add_pair(-3 * One, 4 * One, 0, 0, 0, 0, 1'b1);
    drain();

    // top data bit must be dropped; the unused index must not land anywhere
    set_boxes(10 * One, 32'hFFFF_FFFF, 0);
    write_box(CfgUnused, 5 * One);
    @(negedge clk);
    add_pair(6 * One, 0, 0, 0, 0, 0, 1'b0);
    add_pair(-6 * One, 0, 0, 0, 0, 0, 1'b0);
    add_pair(25 * One, 0, 0, 0, 0, 0, 1'b1);
    add_pair(5 * One, 0, 0, 0, 0, 0, 1'b0);
    add_pair(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 1'b0);
    add_pair(0, 32'h4000_0000, 0, 0, 32'hC000_0000, 0, 1'b0);
    add_pair(0, 0, 32'h1234_5678, 0, 0, 32'hEDCB_A988, 1'b1);
    add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    drain();

    set_boxes(32'h7FFF_FFFF, 1, One);
    add_pair(0, 1, One / 2, 0, 0, 0, 1'b0);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1);
    drain();

    set_boxes($urandom, $urandom, $urandom);
    run_phase(150, 20, 20);

    set_boxes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_phase(100, 30, 10);

    // receiver holds off while requests keep coming, so the pipe backs up
    set_boxes($urandom_range(0, 64 * One), $urandom_range(0, 64 * One),
              $urandom_range(0, 64 * One));
    hold_len = 300;
    run_phase(120, 0, 10);

    set_boxes(0, $urandom, $urandom_range(1, 16 * One));
    run_phase(150, 15, 30);

    set_boxes($urandom, $urandom_range(0, 64 * One), $urandom);
    run_phase(130, 0, 0);

    repeat (50) @(posedge clk);
    $display("Sent %0d point/atom pairs, checked %0d distances (%0d saturated),",
             pairs_sent, dists_checked, sat_seen);
    $display("over %0d box register writes incl. zero, maximum and ignored-index cases",
             box_writes);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pmid_pkg.sv
src/pmid_front.sv
src/pmid_sqrt.sv
src/periodic_min_image_distance_top.sv
bench/periodic_min_image_distance_top_test.sv
